FILE: hdl/egcd_pkg.sv
`default_nettype none

package egcd_pkg;

   typedef struct packed {
      logic [62:0] a_value;
      logic [62:0] b_value;
   } req_type;

   typedef struct packed {
      logic        [62:0] gcd_value;
      logic signed [63:0] coeff_b;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic r2_zero;
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/extended_gcd_coefficient_core.sv
// Extended Euclid core: returns gcd(a, b) and the Bezout coefficient t of b
// (gcd = s*a + t*b), with operands taken from the low WIDTH-1 bits and t
// wrapping at WIDTH bits. One item at a time: start is taken while busy is
// low, and the result appears on rsp_data for exactly one cycle with
// rsp_valid high; the receiver cannot stall, so it must take that beat.
// The strobe follows R Euclid rounds and a final test (R is zero when b is
// zero, at most about 92 at WIDTH = 64); each round is a test state, the
// bit-serial divider, which also builds q*t2 by shift-and-add, and an
// update state. busy falls the cycle after the strobe.
`default_nettype none

module extended_gcd_coefficient_core #(
   parameter int WIDTH = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  egcd_pkg::req_type  req_data,
   output logic               rsp_valid,
   output egcd_pkg::rsp_type  rsp_data
);

   egcd_pkg::cmd_type    cmd;
   egcd_pkg::status_type status;

   egcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   egcd_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

FILE: hdl/egcd_ctrl.sv
`default_nettype none

module egcd_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  egcd_pkg::status_type status,
   output egcd_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_UPD   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.r2_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

`default_nettype wire

FILE: hdl/egcd_datapath.sv
`default_nettype none

module egcd_datapath #(
   parameter int WIDTH = 64
) (
   input  wire                  clock,
   input  egcd_pkg::req_type    req_data,
   input  egcd_pkg::cmd_type    cmd,
   output egcd_pkg::status_type status,
   output egcd_pkg::rsp_type    rsp_data
);

   localparam int CW = $clog2(WIDTH - 1);

   logic [WIDTH-2:0] r1_ff, r2_ff, rem_ff, dvd_ff;
   logic [WIDTH-2:0] r1_in, r2_in, rem_in, dvd_in;
   logic [WIDTH-1:0] t1_ff, t2_ff, acc_ff;
   logic [WIDTH-1:0] t1_in, t2_in, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH:0]   diff;
   logic             qbit;

   // restoring division, one quotient bit a cycle; q*t2 built Horner-style alongside
   assign diff = {1'b0, rem_ff, dvd_ff[WIDTH-2]} - {2'b00, r2_ff};
   assign qbit = ~diff[WIDTH];

   always_comb begin
      r1_in  = r1_ff;
      r2_in  = r2_ff;
      t1_in  = t1_ff;
      t2_in  = t2_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         r1_in = req_data.a_value[WIDTH-2:0];
         r2_in = req_data.b_value[WIDTH-2:0];
         t1_in = '0;
         t2_in = WIDTH'(1);
      end
      if (cmd.div_init) begin
         rem_in = '0;
         dvd_in = r1_ff;
         acc_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = qbit ? diff[WIDTH-2:0] : {rem_ff[WIDTH-3:0], dvd_ff[WIDTH-2]};
         dvd_in = {dvd_ff[WIDTH-3:0], 1'b0};
         acc_in = {acc_ff[WIDTH-2:0], 1'b0} + (qbit ? t2_ff : '0);
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.update) begin
         r1_in = r2_ff;
         r2_in = rem_ff;
         t1_in = t2_ff;
         t2_in = t1_ff - acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      r1_ff  <= r1_in;
      r2_ff  <= r2_in;
      t1_ff  <= t1_in;
      t2_ff  <= t2_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign status.r2_zero  = (r2_ff == '0);
   assign status.div_last = (cnt_ff == CW'(WIDTH - 2));

   assign rsp_data.gcd_value = 63'(r1_ff);
   assign rsp_data.coeff_b   = 64'(signed'(t1_ff));

endmodule

`default_nettype wire

FILE: bench/extended_gcd_coefficient_core_tb.sv
`timescale 1ns / 1ps

module extended_gcd_coefficient_core_tb;

   localparam logic [62:0] OPND_MAX    = {63{1'b1}};
   localparam int          CYCLE_LIMIT = 5_000_000;
   localparam int          DRAIN_CYCLES = 200;

   typedef struct {
      egcd_pkg::req_type req;
      egcd_pkg::rsp_type rsp;
      int                idle_pct;
   } gcd_job_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   egcd_pkg::req_type req_data = '0;
   logic              busy;
   logic              rsp_valid;
   egcd_pkg::rsp_type rsp_data;

   gcd_job_type       job_queue[$];
   egcd_pkg::rsp_type gcd_expected[$];
   egcd_pkg::rsp_type inflight_rsp;
   gcd_job_type       next_job;
   egcd_pkg::rsp_type seen_rsp;
   int                error_count = 0;
   int                cycle_count = 0;
   logic [63:0]       fib[0:92];

   extended_gcd_coefficient_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic egcd_pkg::rsp_type egcd_solve(egcd_pkg::req_type r);
      logic [63:0]       r1, r2, t1, t2, q, rem, tn;
      egcd_pkg::rsp_type p;
      r1 = {1'b0, r.a_value};
      r2 = {1'b0, r.b_value};
      t1 = 64'd0;
      t2 = 64'd1;
      while (r2 != 64'd0) begin
         q   = r1 / r2;
         rem = r1 - q * r2;
         tn  = t1 - q * t2;
         r1  = r2;
         r2  = rem;
         t1  = t2;
         t2  = tn;
      end
      p.gcd_value = r1[62:0];
      p.coeff_b   = t1;
      return p;
   endfunction

   function automatic logic [62:0] rand63();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[62:0];
   endfunction

   task automatic queue_operands(logic [62:0] a, logic [62:0] b, int idle_pct);
      gcd_job_type j;
      j.req.a_value = a;
      j.req.b_value = b;
      j.rsp         = egcd_solve(j.req);
      j.idle_pct    = idle_pct;
      job_queue     = {job_queue, j};
   endtask

   // driver: one beat per start/!busy edge
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            gcd_expected = {gcd_expected, inflight_rsp};
         end
         if (!start || !busy) begin
            if (job_queue.size() != 0 && $urandom_range(99) >= job_queue[0].idle_pct) begin
               next_job = job_queue.pop_front();
               req_data     <= next_job.req;
               inflight_rsp <= next_job.rsp;
               start        <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (gcd_expected.size() == 0) begin
            $display("%0t unexpected result: expected none, got gcd %0d coeff %0d",
                     $time, rsp_data.gcd_value, rsp_data.coeff_b);
            error_count++;
         end else begin
            seen_rsp = gcd_expected.pop_front();
            if (rsp_data.gcd_value !== seen_rsp.gcd_value) begin
               $display("%0t gcd mismatch: expected %0d, got %0d",
                        $time, seen_rsp.gcd_value, rsp_data.gcd_value);
               error_count++;
            end
            if (rsp_data.coeff_b !== seen_rsp.coeff_b) begin
               $display("%0t coeff_b mismatch: expected %0d, got %0d",
                        $time, seen_rsp.coeff_b, rsp_data.coeff_b);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("extended_gcd_coefficient_core_tb: done, errors");
         $finish;
      end
   end

   initial begin
      logic [62:0] a, b, g;
      int          idle, k, n;

      fib[0] = 64'd0;
      fib[1] = 64'd1;
      for (int i = 2; i <= 92; i++) fib[i] = fib[i-1] + fib[i-2];

      // directed
      queue_operands(63'd0, 63'd0, 0);
      queue_operands(OPND_MAX, 63'd0, 0);
      queue_operands(63'd0, OPND_MAX, 0);
      queue_operands(63'd0, 63'd1, 0);
      queue_operands(63'd1, 63'd0, 0);
      queue_operands(63'd1, 63'd1, 0);
      queue_operands(OPND_MAX, OPND_MAX, 0);
      queue_operands(OPND_MAX, 63'd1, 0);
      queue_operands(63'd1, OPND_MAX, 0);
      queue_operands(OPND_MAX, OPND_MAX - 63'd1, 0);
      queue_operands(OPND_MAX - 63'd1, OPND_MAX, 0);
      queue_operands(63'd12, 63'd18, 0);
      queue_operands(63'd240, 63'd46, 0);
      queue_operands(63'd17, 63'd5, 0);
      queue_operands(63'd5, 63'd17, 0);
      queue_operands(fib[92][62:0], fib[91][62:0], 0);
      queue_operands(fib[91][62:0], fib[92][62:0], 0);
      queue_operands(63'h4000_0000_0000_0000, 63'h2000_0000_0000_0000, 0);
      queue_operands(63'h4000_0000_0000_0000, 63'd3, 0);
      queue_operands(OPND_MAX, 63'h4000_0000_0000_0000, 0);
      queue_operands(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 0);
      queue_operands(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 0);

      // random, three idling phases
      for (int i = 0; i < 118; i++) begin
         idle = (i < 39) ? 0 : (i < 79) ? 53 : 18;
         k = $urandom_range(99);
         if (k < 35) begin
            a = rand63();
            b = rand63();
         end else if (k < 55) begin
            g = 63'($urandom_range(20'hFFFFF, 1));
            a = 63'({$urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF)}) * g;
            b = 63'({$urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF)}) * g;
         end else if (k < 70) begin
            a = 63'($urandom_range(255));
            b = 63'($urandom_range(255));
         end else if (k < 85) begin
            a = rand63();
            case ($urandom_range(4))
               0: b = 63'd0;
               1: b = a;
               2: b = 63'd1;
               3: b = a >> $urandom_range(62);
               default: begin
                  b = a;
                  a = 63'd0;
               end
            endcase
         end else begin
            n = $urandom_range(92, 2);
            a = fib[n][62:0];
            b = fib[n-1][62:0];
            if ($urandom_range(1)) begin
               g = a;
               a = b;
               b = g;
            end
         end
         queue_operands(a, b, idle);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (job_queue.size() != 0 || start || gcd_expected.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && gcd_expected.size() == 0) begin
         $display("extended_gcd_coefficient_core_tb: done, clean");
      end else begin
         $display("extended_gcd_coefficient_core_tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: extended_gcd_coefficient_core.f
hdl/egcd_pkg.sv
hdl/egcd_ctrl.sv
hdl/egcd_datapath.sv
hdl/extended_gcd_coefficient_core.sv
bench/extended_gcd_coefficient_core_tb.sv
